FILE: src/ahft_pkg.sv
// shared types and constants of the huffman frequency tracker
package ahft_pkg;

   localparam int SYM_W     = 10;
   localparam int SYM_EXT_W = 13;
   localparam int CMD_W     = 2;
   localparam int NSYM_W    = 11;
   localparam int RATE_W    = 16;
   localparam int IVL_W     = 16;
   localparam int FREQ_W    = 16;
   localparam int CYC_W     = 15;
   localparam int TOT_W     = 16;
   localparam int SUM_W     = 28;
   localparam int PROD_W    = 31;
   localparam int MCP_W     = 28;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CMD_W-1:0] CMD_COUNT      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RESET_ALL  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESET_RATE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_SYMBOLS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADAPT_RATE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_IVL     = 2'd2;

   localparam int NSYM_RESET     = 256;
   localparam int RATE_RESET     = 64;
   localparam int IVL_RESET      = 64;
   localparam int RATE_ZERO      = 64;
   localparam int IVL_ZERO       = 64;
   localparam int RATE_MIN       = 32;
   localparam int SYM_FLOOR      = 24;
   localparam int SYM_PAD        = 6;
   localparam int CYCLE_CAP      = 32767;
   localparam int FREQ_MAX       = 65535;
   localparam int INIT_CYCLE_MAX = 16;
   localparam int RATE_CYCLE_MAX = 8;
   localparam int HALVE_LIMIT    = 32768;
   localparam int GROW_ROUND     = 31;
   localparam int GROW_SHIFT     = 5;

   localparam int MC_RESET_RAW =
      (((NSYM_RESET > SYM_FLOOR) ? NSYM_RESET : SYM_FLOOR) + SYM_PAD) * IVL_RESET;
   localparam int MC_RESET    = (MC_RESET_RAW > CYCLE_CAP) ? CYCLE_CAP : MC_RESET_RAW;
   localparam int CYCLE_RESET = (MC_RESET < INIT_CYCLE_MAX) ? MC_RESET : INIT_CYCLE_MAX;

   typedef enum logic [2:0] {
      KIND_COUNT,
      KIND_CLEAR,
      KIND_RATE,
      KIND_ERROR,
      KIND_REPORT
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [SYM_W-1:0]   symbol;
   } cmd_type;

   typedef struct packed {
      logic               error;
      logic               rebuild_due;
      logic [FREQ_W-1:0]  symbol_frequency;
      logic [CYC_W-1:0]   update_cycle_now;
      logic [TOT_W-1:0]   total_now;
   } rsp_type;

   typedef struct packed {
      logic [CYC_W-1:0]   cycle_ceiling;
      logic [RATE_W-1:0]  rate;
   } sched_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_COUNT,
      S_CLEAR,
      S_HALVE,
      S_GROW,
      S_GROW_CAP,
      S_FETCH,
      S_FETCH_DATA,
      S_EMIT
   } state_type;

endpackage

FILE: src/ahft_queue.sv
// two-entry queue used between front, back and result port
module ahft_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int DEPTH = ahft_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: src/ahft_front.sv
// command classifier ahead of the command queue
module ahft_front #(
   parameter int CNT_W = 11
) (
   input  logic [ahft_pkg::CMD_W-1:0]  command,
   input  logic [ahft_pkg::SYM_W-1:0]  symbol,
   input  logic [CNT_W-1:0]            active,
   output ahft_pkg::cmd_type           item
);

   always_comb begin
      item.symbol = symbol;
      unique case (command)
         ahft_pkg::CMD_COUNT: begin
            item.kind = (int'(symbol) < int'(active)) ? ahft_pkg::KIND_COUNT
                                                      : ahft_pkg::KIND_ERROR;
         end
         ahft_pkg::CMD_RESET_ALL: begin
            item.kind = (active != '0) ? ahft_pkg::KIND_CLEAR : ahft_pkg::KIND_REPORT;
         end
         ahft_pkg::CMD_RESET_RATE: begin
            item.kind = ahft_pkg::KIND_RATE;
         end
         default: begin
            item.kind = ahft_pkg::KIND_ERROR;
         end
      endcase
   end

endmodule

FILE: src/ahft_back.sv
// frequency table, schedule state and the sequencer that carries out commands
module ahft_back #(
   parameter int MAX_SYMBOLS = 1024,
   localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1),
   localparam int ADDR_W = $clog2(MAX_SYMBOLS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_empty,
   input  ahft_pkg::cmd_type    cmd_head,
   output logic                 cmd_pop,
   input  logic                 res_full,
   output logic                 res_push,
   output ahft_pkg::rsp_type    res_data,
   input  logic [CNT_W-1:0]     active,
   input  ahft_pkg::sched_type  sched
);

   localparam int FW = ahft_pkg::FREQ_W;
   localparam int CW = ahft_pkg::CYC_W;
   localparam int TW = ahft_pkg::TOT_W;
   localparam int SW = ahft_pkg::SUM_W;
   localparam int PW = ahft_pkg::PROD_W;
   localparam int XW = ahft_pkg::SYM_EXT_W;

   ahft_pkg::state_type state_ff, state_in;

   logic [FW-1:0]     mem [MAX_SYMBOLS];
   logic [FW-1:0]     q_ff;
   logic              rd_en, wr_en;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [FW-1:0]     wr_data;

   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [SW-1:0]     sum_ff, sum_in;
   ahft_pkg::kind_type kind_ff, kind_in;
   logic [ahft_pkg::SYM_W-1:0] sym_ff, sym_in;
   logic              err_ff, err_in;
   logic              rebuild_ff, rebuild_in;
   logic [FW-1:0]     freq_ff, freq_in;
   logic [TW-1:0]     total_ff, total_in;
   logic [CW-1:0]     cycle_ff, cycle_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [PW-1:0]     prod_ff, prod_in;

   logic [XW-1:0]     head_ext, sym_ext, idx_ext;
   logic              in_table, idx_lt;
   logic [FW:0]       f_inc;
   logic [FW-1:0]     f_sat, halved;
   logic [CW-1:0]     cd_dec, cyc8, cyc16, grow_cap;
   logic [TW:0]       t_add, t_rate;
   logic [31:0]       grow;

   assign head_ext = XW'(cmd_head.symbol);
   assign sym_ext  = XW'(sym_ff);
   assign idx_ext  = XW'(idx_ff);
   assign in_table = int'(sym_ff) < MAX_SYMBOLS;
   assign idx_lt   = idx_ff < active;
   assign f_inc    = (FW+1)'(q_ff) + (FW+1)'(1);
   assign f_sat    = f_inc[FW] ? FW'(ahft_pkg::FREQ_MAX) : f_inc[FW-1:0];
   assign halved   = f_inc[FW:1];
   assign cd_dec   = count_ff - CW'(1);
   assign cyc8     = (cycle_ff > CW'(ahft_pkg::RATE_CYCLE_MAX)) ?
                     CW'(ahft_pkg::RATE_CYCLE_MAX) : cycle_ff;
   assign cyc16    = (sched.cycle_ceiling < CW'(ahft_pkg::INIT_CYCLE_MAX)) ?
                     sched.cycle_ceiling : CW'(ahft_pkg::INIT_CYCLE_MAX);
   assign t_add    = (TW+1)'(total_ff) + (TW+1)'(cycle_ff);
   assign t_rate   = (TW+1)'(total_ff) +
                     ((count_ff < cycle_ff) ? (TW+1)'(cycle_ff - count_ff) : '0);
   assign grow     = (32'(prod_ff) + 32'(ahft_pkg::GROW_ROUND)) >> ahft_pkg::GROW_SHIFT;
   assign grow_cap = (grow > 32'(sched.cycle_ceiling)) ? sched.cycle_ceiling
                                                        : grow[CW-1:0];

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      sum_in       = sum_ff;
      kind_in      = kind_ff;
      sym_in       = sym_ff;
      err_in       = err_ff;
      rebuild_in   = rebuild_ff;
      freq_in      = freq_ff;
      total_in     = total_ff;
      cycle_in     = cycle_ff;
      count_in     = count_ff;
      prod_in      = prod_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      cmd_pop      = 1'b0;
      res_push     = 1'b0;
      res_data     = '{error: err_ff, rebuild_due: rebuild_ff, symbol_frequency: freq_ff,
                       update_cycle_now: cycle_ff, total_now: total_ff};
      unique case (state_ff)
         ahft_pkg::S_INIT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ext[ADDR_W-1:0];
            wr_data = FW'(1);
            if (int'(idx_ff) == MAX_SYMBOLS - 1) begin
               idx_in   = '0;
               state_in = ahft_pkg::S_IDLE;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ahft_pkg::S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop    = 1'b1;
               kind_in    = cmd_head.kind;
               sym_in     = cmd_head.symbol;
               err_in     = 1'b0;
               rebuild_in = 1'b0;
               unique case (cmd_head.kind)
                  ahft_pkg::KIND_COUNT: begin
                     rd_en    = 1'b1;
                     rd_addr  = head_ext[ADDR_W-1:0];
                     state_in = ahft_pkg::S_COUNT;
                  end
                  ahft_pkg::KIND_CLEAR: begin
                     idx_in   = '0;
                     state_in = ahft_pkg::S_CLEAR;
                  end
                  ahft_pkg::KIND_RATE: begin
                     if (t_rate > (TW+1)'(active)) begin
                        idx_in   = '0;
                        pend_in  = 1'b0;
                        sum_in   = '0;
                        state_in = ahft_pkg::S_HALVE;
                     end else begin
                        total_in = t_rate[TW] ? TW'(ahft_pkg::FREQ_MAX) : t_rate[TW-1:0];
                        cycle_in = cyc8;
                        count_in = cyc8;
                        state_in = ahft_pkg::S_FETCH;
                     end
                  end
                  ahft_pkg::KIND_ERROR: begin
                     err_in   = 1'b1;
                     state_in = ahft_pkg::S_FETCH;
                  end
                  default: begin
                     state_in = ahft_pkg::S_FETCH;
                  end
               endcase
            end
         end
         ahft_pkg::S_COUNT: begin
            wr_en    = 1'b1;
            wr_addr  = sym_ext[ADDR_W-1:0];
            wr_data  = f_sat;
            freq_in  = f_sat;
            count_in = cd_dec;
            if (cd_dec != '0) begin
               if (!res_full) begin
                  res_push = 1'b1;
                  res_data = '{error: 1'b0, rebuild_due: 1'b0, symbol_frequency: f_sat,
                               update_cycle_now: cycle_ff, total_now: total_ff};
                  state_in = ahft_pkg::S_IDLE;
               end else begin
                  state_in = ahft_pkg::S_EMIT;
               end
            end else begin
               rebuild_in = 1'b1;
               if (t_add >= (TW+1)'(ahft_pkg::HALVE_LIMIT)) begin
                  idx_in   = '0;
                  pend_in  = 1'b0;
                  sum_in   = '0;
                  state_in = ahft_pkg::S_HALVE;
               end else begin
                  total_in = t_add[TW-1:0];
                  state_in = ahft_pkg::S_GROW;
               end
            end
         end
         ahft_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ext[ADDR_W-1:0];
            wr_data = FW'(1);
            if (idx_ff + CNT_W'(1) == active) begin
               total_in   = TW'(cycle_ff);
               cycle_in   = cyc16;
               count_in   = cyc16;
               rebuild_in = 1'b1;
               state_in   = ahft_pkg::S_FETCH;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ahft_pkg::S_HALVE: begin
            if (idx_lt) begin
               rd_en        = 1'b1;
               rd_addr      = idx_ext[ADDR_W-1:0];
               idx_in       = idx_ff + CNT_W'(1);
               pend_in      = 1'b1;
               pend_addr_in = idx_ext[ADDR_W-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_addr_ff;
               wr_data = halved;
               sum_in  = sum_ff + SW'(halved);
            end
            if (!idx_lt && !pend_ff) begin
               if (kind_ff == ahft_pkg::KIND_COUNT) begin
                  if (sum_ff >= SW'(ahft_pkg::HALVE_LIMIT)) begin
                     idx_in = '0;
                     sum_in = '0;
                  end else begin
                     total_in = sum_ff[TW-1:0];
                     state_in = ahft_pkg::S_GROW;
                  end
               end else begin
                  total_in = (sum_ff > SW'(ahft_pkg::FREQ_MAX)) ?
                             TW'(ahft_pkg::FREQ_MAX) : sum_ff[TW-1:0];
                  cycle_in = cyc8;
                  count_in = cyc8;
                  state_in = ahft_pkg::S_FETCH;
               end
            end
         end
         ahft_pkg::S_GROW: begin
            prod_in  = PW'(cycle_ff) * PW'(sched.rate);
            state_in = ahft_pkg::S_GROW_CAP;
         end
         ahft_pkg::S_GROW_CAP: begin
            cycle_in = grow_cap;
            count_in = grow_cap;
            state_in = ahft_pkg::S_FETCH;
         end
         ahft_pkg::S_FETCH: begin
            rd_en    = in_table;
            rd_addr  = sym_ext[ADDR_W-1:0];
            state_in = ahft_pkg::S_FETCH_DATA;
         end
         ahft_pkg::S_FETCH_DATA: begin
            freq_in  = in_table ? q_ff : '0;
            state_in = ahft_pkg::S_EMIT;
         end
         ahft_pkg::S_EMIT: begin
            if (!res_full) begin
               res_push = 1'b1;
               state_in = ahft_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ahft_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ahft_pkg::S_INIT;
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
         total_ff <= TW'(ahft_pkg::NSYM_RESET);
         cycle_ff <= CW'(ahft_pkg::CYCLE_RESET);
         count_ff <= CW'(ahft_pkg::CYCLE_RESET);
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
         total_ff <= total_in;
         cycle_ff <= cycle_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      sum_ff       <= sum_in;
      kind_ff      <= kind_in;
      sym_ff       <= sym_in;
      err_ff       <= err_in;
      rebuild_ff   <= rebuild_in;
      freq_ff      <= freq_in;
      prod_ff      <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= mem[rd_addr];
      end
   end

endmodule

FILE: src/adaptive_huffman_freq_tracker.sv
// top level of the adaptive huffman frequency tracker
//
// commands enter through a queue port: push with full, one transfer per cycle
// while full is low. each command gives exactly one result on the rsp_ ports,
// held while empty is low and taken by pop. results keep command order.
// a plain count command reads the table in the idle state of the back-end
// sequencer and writes the result back in the count state; the next command
// is taken only back in idle. when the countdown expires and the total plus
// the update cycle reaches 32768, the total is rescaled by walks of the
// active table, repeated while it stays at or above 32768, then the schedule
// is updated and the table read up to the result; reset-all first walks the
// active table, reset-rate and error commands go straight to that read, plus
// one walk when reset-rate halves the table. after reset a pass over all
// MAX_SYMBOLS entries sets the table to one; commands queue meanwhile (two
// deep) and full rises when the queue fills. when pop is held low, two
// results are buffered, then the sequencer waits and the command queue fills
// until full rises. csr_ writes are registered; the user must make them only
// while the block is idle, which the block itself does not enforce.
module adaptive_huffman_freq_tracker #(
   parameter int MAX_SYMBOLS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [ahft_pkg::CMD_W-1:0]    req_command,
   input  logic [ahft_pkg::SYM_W-1:0]    req_symbol,
   output logic                          empty,
   input  logic                          pop,
   output logic                          rsp_error,
   output logic                          rsp_rebuild_due,
   output logic [ahft_pkg::FREQ_W-1:0]   rsp_symbol_frequency,
   output logic [ahft_pkg::CYC_W-1:0]    rsp_update_cycle_now,
   output logic [ahft_pkg::TOT_W-1:0]    rsp_total_now,
   input  logic                          csr_wr_en,
   input  logic [ahft_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ahft_pkg::CSR_DAT_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
   localparam int NW    = ahft_pkg::NSYM_W;
   localparam int RW    = ahft_pkg::RATE_W;
   localparam int IW    = ahft_pkg::IVL_W;
   localparam int MW    = ahft_pkg::MCP_W;
   localparam int CW    = ahft_pkg::CYC_W;

   logic [NW-1:0] nsym_ff, nsym_in;
   logic [RW-1:0] rate_ff, rate_in;
   logic [IW-1:0] ivl_ff, ivl_in;
   logic [CW-1:0] mc_ff, mc_in;

   logic [NW-1:0]    sym_floor;
   logic [NW:0]      sym_pad;
   logic [IW-1:0]    ivl_eff;
   logic [MW-1:0]    mc_prod;
   logic [RW-1:0]    rate_eff;
   logic [CNT_W-1:0] active;

   ahft_pkg::cmd_type   front_item, cmd_head;
   ahft_pkg::rsp_type   res_data, res_head;
   ahft_pkg::sched_type sched;
   logic cmd_empty, cmd_pop, res_full, res_push;

   always_comb begin
      nsym_in = nsym_ff;
      rate_in = rate_ff;
      ivl_in  = ivl_ff;
      if (csr_wr_en) begin
         case (csr_index)
            ahft_pkg::CSR_NUM_SYMBOLS: nsym_in = csr_wdata[NW-1:0];
            ahft_pkg::CSR_ADAPT_RATE:  rate_in = csr_wdata[RW-1:0];
            ahft_pkg::CSR_MAX_IVL:     ivl_in  = csr_wdata[IW-1:0];
            default: ;
         endcase
      end
   end

   assign sym_floor = (nsym_ff > NW'(ahft_pkg::SYM_FLOOR)) ? nsym_ff : NW'(ahft_pkg::SYM_FLOOR);
   assign sym_pad   = (NW+1)'(sym_floor) + (NW+1)'(ahft_pkg::SYM_PAD);
   assign ivl_eff   = (ivl_ff == '0) ? IW'(ahft_pkg::IVL_ZERO) : ivl_ff;
   assign mc_prod   = MW'(sym_pad) * MW'(ivl_eff);
   assign mc_in     = (mc_prod > MW'(ahft_pkg::CYCLE_CAP)) ? CW'(ahft_pkg::CYCLE_CAP)
                                                           : mc_prod[CW-1:0];
   assign rate_eff  = (rate_ff == '0) ? RW'(ahft_pkg::RATE_ZERO) :
                      (rate_ff < RW'(ahft_pkg::RATE_MIN)) ? RW'(ahft_pkg::RATE_MIN) : rate_ff;
   assign active    = (int'(nsym_ff) < MAX_SYMBOLS) ? CNT_W'(nsym_ff) : CNT_W'(MAX_SYMBOLS);
   assign sched     = '{cycle_ceiling: mc_ff, rate: rate_eff};

   always_ff @(posedge clock) begin
      if (reset) begin
         nsym_ff <= NW'(ahft_pkg::NSYM_RESET);
         rate_ff <= RW'(ahft_pkg::RATE_RESET);
         ivl_ff  <= IW'(ahft_pkg::IVL_RESET);
         mc_ff   <= CW'(ahft_pkg::MC_RESET);
      end else begin
         nsym_ff <= nsym_in;
         rate_ff <= rate_in;
         ivl_ff  <= ivl_in;
         mc_ff   <= mc_in;
      end
   end

   ahft_front #(
      .CNT_W (CNT_W)
   ) u_front (
      .command (req_command),
      .symbol  (req_symbol),
      .active  (active),
      .item    (front_item)
   );

   ahft_queue #(
      .WIDTH ($bits(ahft_pkg::cmd_type))
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (front_item),
      .full  (full),
      .pop   (cmd_pop),
      .rdata (cmd_head),
      .empty (cmd_empty)
   );

   ahft_back #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res_data  (res_data),
      .active    (active),
      .sched     (sched)
   );

   ahft_queue #(
      .WIDTH ($bits(ahft_pkg::rsp_type))
   ) u_res_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res_data),
      .full  (res_full),
      .pop   (pop),
      .rdata (res_head),
      .empty (empty)
   );

   assign rsp_error            = res_head.error;
   assign rsp_rebuild_due      = res_head.rebuild_due;
   assign rsp_symbol_frequency = res_head.symbol_frequency;
   assign rsp_update_cycle_now = res_head.update_cycle_now;
   assign rsp_total_now        = res_head.total_now;

   a_res_no_overflow: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result written into a full queue");

   a_cmd_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("command taken from an empty queue");

   a_one_result_per_take: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !res_push)
      else $error("command taken while a result is written");

endmodule
